FILE: rtl/core/ctib_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ctib_pkg;

    localparam int MAX_DIM         = 4096;
    localparam int BYTES_PER_PIXEL = 4;
    localparam int BPP_BITS        = $clog2(BYTES_PER_PIXEL);

    localparam int DIM_W    = 13;
    localparam int WEIGHT_W = 7;
    localparam int BYTE_W   = 8;
    localparam int ROW_W    = 12;
    localparam int COL_W    = 14;
    localparam int CFG_ADDR_W = 3;
    localparam int PROD_W   = BYTE_W + WEIGHT_W;

    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = WEIGHT_W'(100);

    // x / 100 == (x * RECIP_100) >> DIV_SHIFT for every x below 25600
    localparam int DIV_SHIFT = 21;
    localparam logic [PROD_W-1:0] RECIP_100 = PROD_W'(20972);

    localparam logic [BYTE_W-1:0] EMPTY_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] ALPHA_BYTE = 8'h00;

    localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_HEIGHT  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_WIDTH   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SECOND_HEIGHT = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SECOND_WIDTH  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_WEIGHT        = 3'd4;

    typedef struct packed {
        logic [DIM_W-1:0] first_height;
        logic [DIM_W-1:0] first_width;
        logic [DIM_W-1:0] second_height;
        logic [DIM_W-1:0] second_width;
    } dims_t;

    typedef struct packed {
        logic use_first;
        logic use_second;
        logic alpha;
        logic last;
    } place_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0) begin
            r = DIM_W'(1);
        end else if (d > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ctib_place.sv
`timescale 1ns / 1ps
`default_nettype none

module ctib_place (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire ctib_pkg::dims_t dims,
    input  wire logic           advance,
    output ctib_pkg::place_t    place
);
    import ctib_pkg::*;

    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;

    logic [DIM_W-1:0] h1, w1, h2, w2, hb, hs, wb, ws;
    logic             tall2, wide2;
    logic [DIM_W-1:0] h_diff, w_diff;
    logic [DIM_W:0]   h_sum, w_sum;
    logic [ROW_W-1:0] top_row;
    logic [DIM_W-1:0] bot_row;
    logic [ROW_W-1:0] w_diff_half;
    logic [DIM_W-1:0] w_sum_half;
    logic [COL_W-1:0] left_col;
    logic [COL_W:0]   right_col;
    logic [COL_W:0]   row_bytes;
    logic [DIM_W-1:0] row_inc;
    logic [COL_W:0]   col_inc;
    logic             in_v, in_h, row_end, col_end;
    logic             use1, use2;

    always_comb begin
        h1 = clamp_dim(dims.first_height);
        w1 = clamp_dim(dims.first_width);
        h2 = clamp_dim(dims.second_height);
        w2 = clamp_dim(dims.second_width);
        tall2 = h2 > h1;
        wide2 = w2 > w1;
        hb = tall2 ? h2 : h1;
        hs = tall2 ? h1 : h2;
        wb = wide2 ? w2 : w1;
        ws = wide2 ? w1 : w2;

        h_diff = hb - hs;
        w_diff = wb - ws;
        h_sum  = {1'b0, hb} + {1'b0, hs};
        w_sum  = {1'b0, wb} + {1'b0, ws};
        top_row     = h_diff[DIM_W-1:1];
        bot_row     = h_sum[DIM_W:1];
        w_diff_half = w_diff[DIM_W-1:1];
        w_sum_half  = w_sum[DIM_W:1];
        left_col  = COL_W'({w_diff_half, {BPP_BITS{1'b0}}});
        right_col = (COL_W+1)'({w_sum_half, {BPP_BITS{1'b0}}});
        row_bytes = (COL_W+1)'({wb, {BPP_BITS{1'b0}}});

        row_inc = {1'b0, row_reg} + DIM_W'(1);
        col_inc = {1'b0, col_reg} + (COL_W+1)'(1);

        in_v = (row_reg >= top_row) && ({1'b0, row_reg} < bot_row);
        in_h = (col_reg >= left_col) && ({1'b0, col_reg} < right_col);
        row_end = row_inc >= hb;
        col_end = col_inc >= row_bytes;

        use1 = 1'b0;
        use2 = 1'b0;
        if (in_v && in_h) begin
            use1 = 1'b1;
            use2 = 1'b1;
        end else if (in_v) begin
            use1 = !wide2;
            use2 = wide2;
        end else if (in_h) begin
            use1 = !tall2;
            use2 = tall2;
        end else if (tall2 == wide2) begin
            use1 = !tall2;
            use2 = tall2;
        end

        place.use_first  = use1;
        place.use_second = use2;
        place.alpha      = col_reg[BPP_BITS-1:0] == BPP_BITS'(BYTES_PER_PIXEL - 1);
        place.last       = row_end && col_end;

        row_next = row_reg;
        col_next = col_inc[COL_W-1:0];
        if (col_end) begin
            col_next = '0;
            row_next = row_end ? '0 : row_inc[ROW_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (advance) begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ctib_blend.sv
`timescale 1ns / 1ps
`default_nettype none

module ctib_blend (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [ctib_pkg::WEIGHT_W-1:0] weight,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [ctib_pkg::BYTE_W-1:0]   first_byte,
    input  wire logic [ctib_pkg::BYTE_W-1:0]   second_byte,
    input  wire ctib_pkg::place_t              place,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [ctib_pkg::BYTE_W-1:0]        out_byte,
    output ctib_pkg::place_t                   out_place
);
    import ctib_pkg::*;

    logic                st1_valid_reg;
    logic [PROD_W-1:0]   prod_a_reg, prod_b_reg;
    logic [BYTE_W-1:0]   a_reg;
    place_t              st1_place_reg;

    logic                out_valid_reg;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    place_t              out_place_reg;

    logic [WEIGHT_W-1:0] wt, wt_inv;
    logic [PROD_W-1:0]   prod_a_next, prod_b_next;
    logic [2*PROD_W-1:0] scaled_a, scaled_b;
    logic [BYTE_W-1:0]   q_a, q_b;
    logic [BYTE_W:0]     q_sum;
    logic                out_advance, st1_ready;

    assign out_advance = !out_valid_reg || out_ready;
    assign st1_ready   = !st1_valid_reg || out_advance;
    assign in_ready    = st1_ready;

    always_comb begin
        wt = (weight > WEIGHT_FULL) ? WEIGHT_FULL : weight;
        wt_inv = WEIGHT_FULL - wt;
        prod_a_next = PROD_W'(first_byte) * PROD_W'(wt);
        prod_b_next = PROD_W'(second_byte) * PROD_W'(wt_inv);
    end

    always_comb begin
        scaled_a = (2*PROD_W)'(prod_a_reg) * (2*PROD_W)'(RECIP_100);
        scaled_b = (2*PROD_W)'(prod_b_reg) * (2*PROD_W)'(RECIP_100);
        q_a = scaled_a[DIV_SHIFT +: BYTE_W];
        q_b = scaled_b[DIV_SHIFT +: BYTE_W];
        q_sum = {1'b0, q_a} + {1'b0, q_b};
        if (st1_place_reg.alpha) begin
            out_byte_next = ALPHA_BYTE;
        end else if (st1_place_reg.use_first && st1_place_reg.use_second) begin
            out_byte_next = q_sum[BYTE_W-1:0];
        end else if (st1_place_reg.use_first) begin
            out_byte_next = a_reg;
        end else if (st1_place_reg.use_second) begin
            out_byte_next = q_b;
        end else begin
            out_byte_next = EMPTY_BYTE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (st1_ready) begin
                st1_valid_reg <= in_valid;
            end
            if (out_advance) begin
                out_valid_reg <= st1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && st1_ready) begin
            prod_a_reg    <= prod_a_next;
            prod_b_reg    <= prod_b_next;
            a_reg         <= first_byte;
            st1_place_reg <= place;
        end
        if (out_advance && st1_valid_reg) begin
            out_byte_reg  <= out_byte_next;
            out_place_reg <= st1_place_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_place = out_place_reg;

endmodule

`default_nettype wire

FILE: rtl/core/centered_two_image_blend_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | direction | payload
// ----------+-----------+-------------------------------------------------
// s_axis    | in        | tdata: first_byte, second_byte
// m_axis    | out       | tdata: out_byte; tuser: take_first, take_second;
//           |           | tlast: last_byte
// cfg       | in        | write only: cfg_we, cfg_index, cfg_data
//
// one byte per cycle sustained while m_axis does not stall; each accepted
// transaction reaches m_axis through a product stage (byte times weight)
// then a divide by 100 stage (reciprocal multiply) feeding the output register
// aresetn clears the row and column counters, the pipeline valids and the
// configuration to its defaults
// a stall on m_axis holds the output register; s_tready stays high while the
// product stage is empty or can move forward

module centered_two_image_blend_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [15:0]                     s_tdata,   // first_byte, second_byte
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [7:0]                           m_tdata,   // out_byte
    output logic [1:0]                           m_tuser,   // take_first, take_second
    output logic                                 m_tlast,
    input  wire logic                            cfg_we,
    input  wire logic [ctib_pkg::CFG_ADDR_W-1:0] cfg_index,
    input  wire logic [ctib_pkg::DIM_W-1:0]      cfg_data
);
    import ctib_pkg::*;

    dims_t               dims_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    place_t              place;
    place_t              out_place;
    logic [BYTE_W-1:0]   out_byte;
    logic                s_accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg.first_height  <= DIM_W'(1);
            dims_reg.first_width   <= DIM_W'(1);
            dims_reg.second_height <= DIM_W'(1);
            dims_reg.second_width  <= DIM_W'(1);
            weight_reg             <= WEIGHT_W'(50);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FIRST_HEIGHT:  dims_reg.first_height  <= cfg_data;
                CFG_FIRST_WIDTH:   dims_reg.first_width   <= cfg_data;
                CFG_SECOND_HEIGHT: dims_reg.second_height <= cfg_data;
                CFG_SECOND_WIDTH:  dims_reg.second_width  <= cfg_data;
                CFG_WEIGHT:        weight_reg             <= cfg_data[WEIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_accept = s_tvalid && s_tready;

    ctib_place u_place (
        .aclk    (aclk),
        .aresetn (aresetn),
        .dims    (dims_reg),
        .advance (s_accept),
        .place   (place)
    );

    ctib_blend u_blend (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .weight      (weight_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .first_byte  (s_tdata[7:0]),
        .second_byte (s_tdata[15:8]),
        .place       (place),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_byte    (out_byte),
        .out_place   (out_place)
    );

    assign m_tdata = out_byte;
    assign m_tuser = {out_place.use_second, out_place.use_first};
    assign m_tlast = out_place.last;

    // empty canvas area shows white or a zero alpha byte
    a_empty_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0] && !m_tuser[1]) |-> (m_tdata == EMPTY_BYTE
            || m_tdata == ALPHA_BYTE))
        else $error("empty area byte is not white or alpha");

    // m_tvalid is high once an accepted transaction has passed the product and output registers
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |-> ##2 m_tvalid)
        else $error("result missing two cycles after accept");

endmodule

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import ctib_pkg::*;

    localparam int TOTAL_ITEMS  = 1450;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 3000;
    localparam int PIPE_SETTLE  = 4;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       take_first;
        logic       take_second;
        logic       last_byte;
    } canvas_byte_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;   // first_byte, second_byte
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;   // out_byte
    logic [1:0]            m_tuser;   // take_first, take_second
    logic                  m_tlast;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_index;
    logic [DIM_W-1:0]      cfg_data;

    // canvas model state
    logic [DIM_W-1:0]    first_h, first_w, second_h, second_w;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [ROW_W-1:0]    row_pos;
    logic [COL_W-1:0]    col_pos;

    canvas_byte_t expected_bytes[$];

    int unsigned items_sent;
    int unsigned bytes_checked;
    int unsigned frame_ends;
    int unsigned blended_bytes;
    int unsigned empty_bytes;
    int unsigned settings_used;
    int unsigned mismatch_count;
    int unsigned quiet_cycles;
    bit          steady;
    bit          hold_request;

    centered_two_image_blend_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int unsigned usable_dim(input logic [DIM_W-1:0] d);
        int unsigned v;
        v = d;
        if (v == 0) v = 1;
        if (v > MAX_DIM) v = MAX_DIM;
        return v;
    endfunction

    // computes the canvas byte at the current position and steps the raster counters
    function automatic canvas_byte_t next_canvas_byte(input logic [7:0] a, input logic [7:0] b);
        int unsigned h1, w1, h2, w2, wt, hb, hs, wb, ws;
        int unsigned top, bot, left, right, row_bytes, row, col;
        logic tall2, wide2, in_v, in_h;
        canvas_byte_t r;
        h1 = usable_dim(first_h);
        w1 = usable_dim(first_w);
        h2 = usable_dim(second_h);
        w2 = usable_dim(second_w);
        wt = (weight_reg > 7'd100) ? 100 : weight_reg;
        tall2 = h2 > h1;
        wide2 = w2 > w1;
        hb = tall2 ? h2 : h1;
        hs = tall2 ? h1 : h2;
        wb = wide2 ? w2 : w1;
        ws = wide2 ? w1 : w2;
        top = (hb - hs) / 2;
        bot = (hb + hs) / 2;
        left = ((wb - ws) / 2) * BYTES_PER_PIXEL;
        right = ((wb + ws) / 2) * BYTES_PER_PIXEL;
        row_bytes = wb * BYTES_PER_PIXEL;
        row = row_pos;
        col = col_pos;
        in_v = (top <= row) && (row < bot);
        in_h = (left <= col) && (col < right);
        r.take_first = 1'b0;
        r.take_second = 1'b0;
        if (in_v && in_h) begin
            r.take_first = 1'b1;
            r.take_second = 1'b1;
        end else if (in_v) begin
            r.take_first = !wide2;
            r.take_second = wide2;
        end else if (in_h) begin
            r.take_first = !tall2;
            r.take_second = tall2;
        end else if (tall2 == wide2) begin
            r.take_first = !tall2;
            r.take_second = tall2;
        end
        if ((col + 1) % BYTES_PER_PIXEL == 0) begin
            r.out_byte = ALPHA_BYTE;
        end else if (r.take_first && r.take_second) begin
            r.out_byte = 8'(int'(a) * wt / 100 + int'(b) * (100 - wt) / 100);
        end else if (r.take_first) begin
            r.out_byte = a;
        end else if (r.take_second) begin
            r.out_byte = 8'(int'(b) * (100 - wt) / 100);
        end else begin
            r.out_byte = EMPTY_BYTE;
        end
        r.last_byte = (row + 1 >= hb) && (col + 1 >= row_bytes);
        if (col + 1 >= row_bytes) begin
            col_pos = '0;
            row_pos = (row + 1 >= hb) ? '0 : ROW_W'(row + 1);
        end else begin
            col_pos = COL_W'(col + 1);
        end
        return r;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 90) return DIM_W'($urandom_range(1, 8));
        if (roll < 92) return '0;
        if (roll < 95) return DIM_W'(MAX_DIM);
        if (roll < 98) return DIM_W'($urandom_range(MAX_DIM + 1, 8191));
        return DIM_W'($urandom_range(1, 8191));
    endfunction

    function automatic logic [DIM_W-1:0] pick_weight();
        int unsigned roll;
        logic [WEIGHT_W-1:0] w;
        roll = $urandom_range(99);
        if (roll < 10) w = 7'd0;
        else if (roll < 20) w = 7'd100;
        else if (roll < 30) w = 7'($urandom_range(101, 127));
        else w = 7'($urandom_range(100));
        // upper data bits are ignored by a weight register
        if ($urandom_range(3) == 0) return {6'($urandom_range(63)), w};
        return {6'd0, w};
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [DIM_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        case (idx)
            CFG_FIRST_HEIGHT:  first_h = val;
            CFG_FIRST_WIDTH:   first_w = val;
            CFG_SECOND_HEIGHT: second_h = val;
            CFG_SECOND_WIDTH:  second_w = val;
            CFG_WEIGHT:        weight_reg = val[WEIGHT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_canvas(input logic [DIM_W-1:0] h1, input logic [DIM_W-1:0] w1,
                              input logic [DIM_W-1:0] h2, input logic [DIM_W-1:0] w2,
                              input logic [DIM_W-1:0] wdata);
        write_reg(CFG_FIRST_HEIGHT, h1);
        write_reg(CFG_FIRST_WIDTH, w1);
        write_reg(CFG_SECOND_HEIGHT, h2);
        write_reg(CFG_SECOND_WIDTH, w2);
        write_reg(CFG_WEIGHT, wdata);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic send_pair(input logic [7:0] a, input logic [7:0] b);
        while (!steady && $urandom_range(99) < 15) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_bytes.push_back(next_canvas_byte(a, b));
        items_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (PIPE_SETTLE) @(posedge aclk);
    endtask

    task automatic run_random_phase(input int unsigned burst);
        wait_idle();
        set_canvas(pick_dim(), pick_dim(), pick_dim(), pick_dim(), pick_weight());
        repeat (burst) send_pair(pick_byte(), pick_byte());
    endtask

    // reset configuration is one pixel per image at half weight
    task automatic test_default_canvas();
        send_pair(8'd0, 8'd255);
        send_pair(8'd255, 8'd0);
        send_pair(8'd255, 8'd255);
        send_pair(8'd255, 8'd255);
    endtask

    // 2x2 canvas: overlap, first only, second only and empty pixels in turn
    task automatic test_region_weights();
        wait_idle();
        set_canvas(13'd1, 13'd2, 13'd2, 13'd1, 13'd0);
        send_pair(8'd255, 8'd255);
        send_pair(8'd0, 8'd255);
        send_pair(8'd255, 8'd0);
        send_pair(8'd170, 8'd85);
        wait_idle();
        write_reg(CFG_WEIGHT, 13'd100);
        cfg_we <= 1'b0;
        send_pair(8'd255, 8'd0);
        send_pair(8'd0, 8'd255);
        send_pair(8'd128, 8'd127);
        send_pair(8'd1, 8'd254);
        wait_idle();
        write_reg(CFG_WEIGHT, 13'd127);
        cfg_we <= 1'b0;
        send_pair(8'd0, 8'd255);
        send_pair(8'd255, 8'd255);
        send_pair(8'd85, 8'd170);
        send_pair(8'd7, 8'd200);
        wait_idle();
        write_reg(CFG_WEIGHT, 13'd37);
        cfg_we <= 1'b0;
        send_pair(8'd255, 8'd255);
        send_pair(8'd0, 8'd0);
        send_pair(8'd255, 8'd0);
        send_pair(8'd0, 8'd255);
    endtask

    // zero and oversized dimensions
    task automatic test_dim_clamping();
        wait_idle();
        set_canvas(13'd0, 13'd8191, DIM_W'(MAX_DIM), 13'd0, 13'd50);
        send_pair(8'd255, 8'd0);
        send_pair(8'd0, 8'd255);
        send_pair(8'd200, 8'd100);
        send_pair(8'd255, 8'd255);
    endtask

    task automatic test_steady_stream();
        steady = 1'b1;
        run_random_phase(250);
        steady = 1'b0;
    endtask

    task automatic test_output_backpressure();
        hold_request = 1'b1;
        run_random_phase(120);
    endtask

    task automatic test_random_frames();
        while (items_sent < TOTAL_ITEMS) run_random_phase($urandom_range(20, 120));
    endtask

    initial begin : ready_driver
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                for (int i = 0; i < HOLD_CYCLES; i++) @(posedge aclk);
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 15);
            end
        end
    end

    always @(posedge aclk) begin
        canvas_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bytes.size() == 0) begin
                $error("canvas byte %0h arrived with no transaction outstanding", m_tdata);
                mismatch_count++;
            end else begin
                want = expected_bytes.pop_front();
                bytes_checked++;
                if (want.last_byte) frame_ends++;
                if (want.take_first && want.take_second) blended_bytes++;
                if (!want.take_first && !want.take_second) empty_bytes++;
                if (m_tdata !== want.out_byte) begin
                    $error("out_byte: expected %0d, got %0d", want.out_byte, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser[0] !== want.take_first) begin
                    $error("take_first: expected %0d, got %0d", want.take_first, m_tuser[0]);
                    mismatch_count++;
                end
                if (m_tuser[1] !== want.take_second) begin
                    $error("take_second: expected %0d, got %0d", want.take_second, m_tuser[1]);
                    mismatch_count++;
                end
                if (m_tlast !== want.last_byte) begin
                    $error("last_byte: expected %0d, got %0d", want.last_byte, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", quiet_cycles);
            $display("centered_two_image_blend_top test failed");
            $finish;
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        steady       = 1'b0;
        hold_request = 1'b0;
        quiet_cycles = 0;
        first_h      = 13'd1;
        first_w      = 13'd1;
        second_h     = 13'd1;
        second_w     = 13'd1;
        weight_reg   = 7'd50;
        row_pos      = '0;
        col_pos      = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_default_canvas();
        test_region_weights();
        test_dim_clamping();
        test_steady_stream();
        test_output_backpressure();
        test_random_frames();
        wait_idle();
        $display("checked %0d canvas bytes over %0d image settings, %0d frame ends",
                 bytes_checked, settings_used, frame_ends);
        $display("%0d blended bytes, %0d empty bytes, one long output stall",
                 blended_bytes, empty_bytes);
        if (mismatch_count == 0) begin
            $display("centered_two_image_blend_top test passed");
        end else begin
            $display("centered_two_image_blend_top test failed");
        end
        $finish;
    end

endmodule
